@@ rtl/core/cas_pkg.sv @@
// cas_pkg: shared types, stage count and calendar tables for the calendar second adder
// holds the request and result transfer structs used by calendar_add_seconds_core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

  localparam int STAGES = 12;

  typedef struct packed {
    logic [13:0]        in_year;
    logic [3:0]         in_month;
    logic [4:0]         in_day;
    logic [4:0]         in_hour;
    logic [5:0]         in_minute;
    logic [5:0]         in_second;
    logic signed [31:0] offset_seconds;
  } request_t;

  typedef struct packed {
    logic signed [14:0] out_year;
    logic [3:0]         out_month;
    logic [4:0]         out_day;
    logic [4:0]         out_hour;
    logic [5:0]         out_minute;
    logic [5:0]         out_second;
  } result_t;

  // days from march 1 to the first of the month, months counted from march
  function automatic logic [8:0] mp_base(input logic [3:0] mp);
    logic [8:0] base;
    unique case (mp)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      4'd12:   base = 9'd367;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

  // whole centuries in a year of era
  function automatic logic [1:0] centuries(input logic [8:0] yoe);
    logic [1:0] c;
    if (yoe >= 9'd300) begin
      c = 2'd3;
    end else if (yoe >= 9'd200) begin
      c = 2'd2;
    end else if (yoe >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/calendar_add_seconds_core.sv @@
// calendar_add_seconds_core: adds a signed second offset to a gregorian date and time
// twelve-stage pipeline, days_from_civil / civil_from_days with reciprocal multipliers
// depends on cas_pkg
//
// channel   direction  handshake            payload
// request   in         start, busy          cas_pkg::request_t
// result    out        done (one cycle)     cas_pkg::result_t
//
// one request per cycle; busy never rises
// a request taken at one edge shows its result once it has passed stage registers s1 to s11 and the result register
// the depth comes from the chain of constant-reciprocal multipliers, at most one per stage
// rst clears the stage valid bits only; payload registers are not reset
// the receiver cannot stall, so results leave in the cycle they are done
`timescale 1ns / 1ps
`default_nettype none

module calendar_add_seconds_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire cas_pkg::request_t request,
  output logic                   done,
  output cas_pkg::result_t       result
);

  localparam logic [13:0] RECIP_400   = 14'd10486;
  localparam logic [30:0] RECIP_675   = 31'd1628906116;
  localparam logic [16:0] RECIP_3600  = 17'd74566;
  localparam logic [22:0] RECIP_ERA   = 23'd7525902;
  localparam logic [12:0] RECIP_60    = 13'd4370;
  localparam logic [15:0] RECIP_365   = 16'd45965;
  localparam logic [12:0] RECIP_153   = 13'd6854;
  localparam logic [25:0] OFFSET_BIAS = 26'd16777800;
  localparam logic [23:0] DAY_BIAS    = 24'd24856;

  logic [cas_pkg::STAGES-1:0] vld;

  // stage 1
  logic        mon_lo;
  logic [3:0]  mp_in;
  logic [28:0] q400_prod;
  logic [14:0] s1_yp_next;
  logic [9:0]  s1_doy_next;
  logic [16:0] s1_tod_next;
  logic [25:0] s1_ap_next;
  logic [14:0] s1_yp;
  logic [5:0]  s1_q400;
  logic [9:0]  s1_doy;
  logic [16:0] s1_tod;
  logic [25:0] s1_ap;
  logic [6:0]  s1_lo7;

  // stage 2
  logic [14:0] yoe_wide;
  logic [55:0] qo_prod;
  logic [8:0]  s2_yoe;
  logic [5:0]  s2_q400;
  logic [9:0]  s2_doy;
  logic [16:0] s2_tod;
  logic [25:0] s2_ap;
  logic [15:0] s2_qo;
  logic [6:0]  s2_lo7;

  // stage 3
  logic [18:0] s3_doe_next;
  logic [25:0] r675_wide;
  logic [17:0] s3_rest0_next;
  logic [18:0] s3_doe;
  logic [5:0]  s3_q400;
  logic [15:0] s3_qo;
  logic [17:0] s3_rest0;

  // stage 4
  logic [23:0] zsum_wide;
  logic [1:0]  s4_carry_next;
  logic [16:0] s4_rest_next;
  logic [22:0] s4_zsum;
  logic [1:0]  s4_carry;
  logic [16:0] s4_rest;

  // stage 5
  logic [33:0] hour_prod;
  logic [22:0] s5_zp;
  logic [16:0] s5_rest;
  logic [4:0]  s5_hour;

  // stage 6
  logic [45:0] qz_prod;
  logic [16:0] remh_wide;
  logic [22:0] s6_zp;
  logic [5:0]  s6_qz;
  logic [11:0] s6_remh;
  logic [4:0]  s6_hour;

  // stage 7
  logic [22:0] doe2_wide;
  logic [24:0] min_prod;
  logic [17:0] s7_doe2;
  logic [5:0]  s7_qz;
  logic [11:0] s7_remh;
  logic [4:0]  s7_hour;
  logic [5:0]  s7_minute;

  // stage 8
  logic [31:0] n1460_prod;
  logic [2:0]  s8_k_next;
  logic [11:0] sec_wide;
  logic [17:0] s8_doe2;
  logic [5:0]  s8_qz;
  logic [6:0]  s8_n1460;
  logic [2:0]  s8_k;
  logic [4:0]  s8_hour;
  logic [5:0]  s8_minute;
  logic [5:0]  s8_second;

  // stage 9
  logic [17:0] t_val;
  logic [33:0] yoe2_prod;
  logic [17:0] s9_doe2;
  logic [5:0]  s9_qz;
  logic [8:0]  s9_yoe2;
  logic [4:0]  s9_hour;
  logic [5:0]  s9_minute;
  logic [5:0]  s9_second;

  // stage 10
  logic [17:0] doy2_wide;
  logic [5:0]  s10_qz;
  logic [8:0]  s10_yoe2;
  logic [8:0]  s10_doy2;
  logic [4:0]  s10_hour;
  logic [5:0]  s10_minute;
  logic [5:0]  s10_second;

  // stage 11
  logic [10:0] mp_num;
  logic [23:0] mp_prod;
  logic [5:0]  s11_qz;
  logic [8:0]  s11_yoe2;
  logic [8:0]  s11_doy2;
  logic [3:0]  s11_mp;
  logic [4:0]  s11_hour;
  logic [5:0]  s11_minute;
  logic [5:0]  s11_second;

  // stage 12
  logic [8:0]        day_wide;
  logic [3:0]        month_next;
  logic              month_lo;
  logic [14:0]       year_next;
  cas_pkg::result_t  result_next;

  assign busy = 1'b0;
  assign done = vld[cas_pkg::STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[cas_pkg::STAGES-2:0], start};
    end
  end

  // days from civil: shifted year, era, day of year, time of day, offset split; then civil from days
  always_comb begin
    mon_lo        = (request.in_month <= 4'd2);
    mp_in         = mon_lo ? (request.in_month + 4'd9) : (request.in_month - 4'd3);
    s1_yp_next    = {1'b0, request.in_year} + 15'd400 - {14'd0, mon_lo};
    q400_prod     = 29'(s1_yp_next) * 29'(RECIP_400);
    s1_doy_next   = {1'b0, cas_pkg::mp_base(mp_in)} + {5'd0, request.in_day} - 10'd1;
    s1_tod_next   = 17'(request.in_hour) * 17'd3600 + 17'(request.in_minute) * 17'd60
                  + 17'(request.in_second);
    s1_ap_next    = {request.offset_seconds[31], request.offset_seconds[31:7]}
                  + OFFSET_BIAS;

    yoe_wide      = s1_yp - 15'(s1_q400) * 15'd400;
    qo_prod       = 56'(s1_ap) * 56'(RECIP_675);

    s3_doe_next   = 19'(s2_yoe) * 19'd365 + 19'(s2_yoe[8:2])
                  - 19'(cas_pkg::centuries(s2_yoe)) + {{9{s2_doy[9]}}, s2_doy};
    r675_wide     = s2_ap - 26'(s2_qo) * 26'd675;
    s3_rest0_next = 18'(s2_tod) + 18'({r675_wide[9:0], s2_lo7});

    zsum_wide     = 24'(s3_q400) * 24'd146097 + {{5{s3_doe[18]}}, s3_doe}
                  + 24'(s3_qo) - DAY_BIAS;
    if (s3_rest0 >= 18'd172800) begin
      s4_carry_next = 2'd2;
      s4_rest_next  = 17'(s3_rest0 - 18'd172800);
    end else if (s3_rest0 >= 18'd86400) begin
      s4_carry_next = 2'd1;
      s4_rest_next  = 17'(s3_rest0 - 18'd86400);
    end else begin
      s4_carry_next = 2'd0;
      s4_rest_next  = s3_rest0[16:0];
    end

    hour_prod     = 34'(s4_rest) * 34'(RECIP_3600);

    qz_prod       = 46'(s5_zp) * 46'(RECIP_ERA);
    remh_wide     = s5_rest - 17'(s5_hour) * 17'd3600;

    doe2_wide     = s6_zp - 23'(s6_qz) * 23'd146097;
    min_prod      = 25'(s6_remh) * 25'(RECIP_60);

    n1460_prod    = 32'(s7_doe2[17:2]) * 32'(RECIP_365);
    s8_k_next     = 3'(s7_doe2 >= 18'd36524) + 3'(s7_doe2 >= 18'd73048)
                  + 3'(s7_doe2 >= 18'd109572) + 3'(s7_doe2 >= 18'd146096)
                  - 3'(s7_doe2 == 18'd146096);
    sec_wide      = s7_remh - 12'(s7_minute) * 12'd60;

    t_val         = s8_doe2 - 18'(s8_n1460) + 18'(s8_k);
    yoe2_prod     = 34'(t_val) * 34'(RECIP_365);

    doy2_wide     = s9_doe2 - (18'(s9_yoe2) * 18'd365 + 18'(s9_yoe2[8:2])
                  - 18'(cas_pkg::centuries(s9_yoe2)));

    mp_num        = 11'(s10_doy2) * 11'd5 + 11'd2;
    mp_prod       = 24'(mp_num) * 24'(RECIP_153);

    day_wide      = s11_doy2 - cas_pkg::mp_base(s11_mp) + 9'd1;
    month_next    = (s11_mp < 4'd10) ? (s11_mp + 4'd3) : (s11_mp - 4'd9);
    month_lo      = (month_next <= 4'd2);
    year_next     = 15'(s11_yoe2) + 15'(s11_qz) * 15'd400 - 15'd400 + 15'(month_lo);

    result_next.out_year   = $signed(year_next);
    result_next.out_month  = month_next;
    result_next.out_day    = day_wide[4:0];
    result_next.out_hour   = s11_hour;
    result_next.out_minute = s11_minute;
    result_next.out_second = s11_second;
  end

  always_ff @(posedge clk) begin
    s1_yp      <= s1_yp_next;
    s1_q400    <= q400_prod[27:22];
    s1_doy     <= s1_doy_next;
    s1_tod     <= s1_tod_next;
    s1_ap      <= s1_ap_next;
    s1_lo7     <= request.offset_seconds[6:0];

    s2_yoe     <= yoe_wide[8:0];
    s2_q400    <= s1_q400;
    s2_doy     <= s1_doy;
    s2_tod     <= s1_tod;
    s2_ap      <= s1_ap;
    s2_qo      <= qo_prod[55:40];
    s2_lo7     <= s1_lo7;

    s3_doe     <= s3_doe_next;
    s3_q400    <= s2_q400;
    s3_qo      <= s2_qo;
    s3_rest0   <= s3_rest0_next;

    s4_zsum    <= zsum_wide[22:0];
    s4_carry   <= s4_carry_next;
    s4_rest    <= s4_rest_next;

    s5_zp      <= s4_zsum + 23'(s4_carry);
    s5_rest    <= s4_rest;
    s5_hour    <= hour_prod[32:28];

    s6_zp      <= s5_zp;
    s6_qz      <= qz_prod[45:40];
    s6_remh    <= remh_wide[11:0];
    s6_hour    <= s5_hour;

    s7_doe2    <= doe2_wide[17:0];
    s7_qz      <= s6_qz;
    s7_remh    <= s6_remh;
    s7_hour    <= s6_hour;
    s7_minute  <= min_prod[23:18];

    s8_doe2    <= s7_doe2;
    s8_qz      <= s7_qz;
    s8_n1460   <= n1460_prod[30:24];
    s8_k       <= s8_k_next;
    s8_hour    <= s7_hour;
    s8_minute  <= s7_minute;
    s8_second  <= sec_wide[5:0];

    s9_doe2    <= s8_doe2;
    s9_qz      <= s8_qz;
    s9_yoe2    <= yoe2_prod[32:24];
    s9_hour    <= s8_hour;
    s9_minute  <= s8_minute;
    s9_second  <= s8_second;

    s10_qz     <= s9_qz;
    s10_yoe2   <= s9_yoe2;
    s10_doy2   <= doy2_wide[8:0];
    s10_hour   <= s9_hour;
    s10_minute <= s9_minute;
    s10_second <= s9_second;

    s11_qz     <= s10_qz;
    s11_yoe2   <= s10_yoe2;
    s11_doy2   <= s10_doy2;
    s11_mp     <= mp_prod[23:20];
    s11_hour   <= s10_hour;
    s11_minute <= s10_minute;
    s11_second <= s10_second;

    result     <= result_next;
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##12 done)
    else $error("transfer did not complete after pipeline latency");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##12 !done)
    else $error("result strobe without a matching request");

  a_day_split: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (s4_rest < 17'd86400) && (s4_carry <= 2'd2))
    else $error("second of day out of range after carry");

  a_doe_range: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (s7_doe2 <= 18'd146096))
    else $error("day of era out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_hour < 5'd24) && (result.out_minute < 6'd60)
             && (result.out_second < 6'd60))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_month >= 4'd1) && (result.out_month <= 4'd12)
             && (result.out_day != 5'd0))
    else $error("month or day out of range");
`endif

endmodule

`default_nettype wire

@@ verif/calendar_add_seconds_core_tb.sv @@
// calendar_add_seconds_core_tb: directed table plus random requests, each result checked
// against its typed row or an in-bench calendar predictor; depends on cas_pkg and calendar_add_seconds_core
`timescale 1ns / 1ps

module calendar_add_seconds_core_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PER_PHASE = 138;

  typedef struct {
    cas_pkg::request_t req;
    bit                typed;
    cas_pkg::result_t  res;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  cas_pkg::request_t request = '0;
  logic              done;
  cas_pkg::result_t  result;

  cas_pkg::result_t  pending_times [$];
  int       errors = 0;
  int       idle_pct = 0;
  int       quiet_cycles = 0;
  int       phase_idle [4] = '{0, 64, 0, 23};

  // typed expectations only where the answer is plain; the rest go through the predictor
  directed_row_t directed_rows [$] = '{
    '{'{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'sd0}, 1'b1,
      '{15'sd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{'{14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'sd1}, 1'b1,
      '{15'sd10000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{'{14'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, -32'sd1}, 1'b1,
      '{15'sd0, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{'{14'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 32'sd1}, 1'b1,
      '{15'sd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}},
    '{'{14'd1900, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 32'sd1}, 1'b1,
      '{15'sd1900, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{'{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'sh7fffffff}, 1'b1,
      '{15'sd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7}},
    '{'{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'sh80000000}, 1'b1,
      '{15'sd1901, 4'd12, 5'd13, 5'd20, 6'd45, 6'd52}},
    '{'{14'd2024, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, -32'sd1}, 1'b1,
      '{15'sd2024, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59}},
    '{'{14'd2023, 4'd3, 5'd0, 5'd12, 6'd0, 6'd0, 32'sd0}, 1'b1,
      '{15'sd2023, 4'd2, 5'd28, 5'd12, 6'd0, 6'd0}},
    '{'{14'd2023, 4'd0, 5'd15, 5'd0, 6'd0, 6'd0, 32'sd0}, 1'b1,
      '{15'sd2022, 4'd12, 5'd15, 5'd0, 6'd0, 6'd0}},
    '{'{14'd2023, 4'd13, 5'd15, 5'd0, 6'd0, 6'd0, 32'sd0}, 1'b1,
      '{15'sd2024, 4'd1, 5'd15, 5'd0, 6'd0, 6'd0}},
    '{'{14'd2023, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0, 32'sd0}, 1'b1,
      '{15'sd2023, 4'd3, 5'd3, 5'd0, 6'd0, 6'd0}},
    '{'{14'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'sd0}, 1'b1,
      '{15'sd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{'{14'd2100, 4'd2, 5'd28, 5'd12, 6'd0, 6'd0, 32'sd86400}, 1'b1,
      '{15'sd2100, 4'd3, 5'd1, 5'd12, 6'd0, 6'd0}},
    '{'{14'd2023, 4'd14, 5'd15, 5'd0, 6'd0, 6'd0, 32'sd0}, 1'b0, '0},
    '{'{14'd2023, 4'd15, 5'd31, 5'd0, 6'd0, 6'd0, 32'sd0}, 1'b0, '0},
    '{'{14'd2023, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63, 32'sd0}, 1'b0, '0},
    '{'{14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'sh7fffffff}, 1'b0, '0},
    '{'{14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'sh80000000}, 1'b0, '0},
    '{'{14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'sh7fffffff}, 1'b0, '0},
    '{'{14'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'sh80000000}, 1'b0, '0}
  };

  calendar_add_seconds_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if (a % b < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic cas_pkg::result_t shifted_time(input cas_pkg::request_t r);
    longint  y, m, dd, hh, mi, ss, off;
    longint  era, yoe, doy, doe, days, total, rest, mp;
    cas_pkg::result_t t;
    y   = r.in_year;
    m   = r.in_month;
    dd  = r.in_day;
    hh  = r.in_hour;
    mi  = r.in_minute;
    ss  = r.in_second;
    off = r.offset_seconds;
    // date to days since 1970-01-01, years counted from march
    if (m <= 2) begin
      y = y - 1;
    end
    era   = floor_quot(y, 400);
    yoe   = y - era * 400;
    doy   = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + dd - 1;
    doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days  = era * 146097 + doe - 719468;
    total = days * 86400 + hh * 3600 + mi * 60 + ss + off;
    days  = floor_quot(total, 86400);
    rest  = total - days * 86400;
    // days back to a civil date
    days = days + 719468;
    era  = floor_quot(days, 146097);
    doe  = days - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dd   = doy - (153 * mp + 2) / 5 + 1;
    m    = mp + (mp < 10 ? 3 : -9);
    y    = yoe + era * 400 + (m <= 2 ? 1 : 0);
    t.out_year   = 15'(y);
    t.out_month  = 4'(m);
    t.out_day    = 5'(dd);
    t.out_hour   = 5'(rest / 3600);
    t.out_minute = 6'((rest % 3600) / 60);
    t.out_second = 6'(rest % 60);
    return t;
  endfunction

  function automatic cas_pkg::request_t random_request();
    cas_pkg::request_t r;
    int       month_len;
    int       year;
    if ($urandom_range(99) < 10) begin
      // noise: every field over its full width
      r.in_year        = 14'($urandom);
      r.in_month       = 4'($urandom);
      r.in_day         = 5'($urandom);
      r.in_hour        = 5'($urandom);
      r.in_minute      = 6'($urandom);
      r.in_second      = 6'($urandom);
      r.offset_seconds = $urandom;
      return r;
    end
    if ($urandom_range(9) == 0) begin
      year = $urandom_range(1) ? 9999 : 1;
    end else begin
      year = $urandom_range(9999, 1);
    end
    r.in_year  = 14'(year);
    r.in_month = 4'($urandom_range(12, 1));
    case (r.in_month) inside
      4'd2: begin
        month_len = ((year % 4 == 0 && year % 100 != 0) || year % 400 == 0) ? 29 : 28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        month_len = 30;
      end
      default: begin
        month_len = 31;
      end
    endcase
    r.in_day    = 5'($urandom_range(month_len, 1));
    r.in_hour   = 5'($urandom_range(23));
    r.in_minute = 6'($urandom_range(59));
    r.in_second = 6'($urandom_range(59));
    case ($urandom_range(3))
      0: begin
        r.offset_seconds = int'($urandom_range(200000)) - 100000;
      end
      1: begin
        r.offset_seconds = (int'($urandom_range(48000)) - 24000) * 86400
                           + int'($urandom_range(2)) - 1;
      end
      2: begin
        r.offset_seconds = $urandom;
      end
      default: begin
        r.offset_seconds = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      end
    endcase
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic drive_request(input cas_pkg::request_t r, input bit typed,
                               input cas_pkg::result_t typed_res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_times.push_back(typed ? typed_res : shifted_time(r));
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    cas_pkg::result_t want;
    if (!rst && done) begin
      if (pending_times.size() == 0) begin
        $error("result transfer with nothing pending");
        errors++;
      end else begin
        want = pending_times.pop_front();
        check_field("out_year", want.out_year, result.out_year);
        check_field("out_month", want.out_month, result.out_month);
        check_field("out_day", want.out_day, result.out_day);
        check_field("out_hour", want.out_hour, result.out_hour);
        check_field("out_minute", want.out_minute, result.out_minute);
        check_field("out_second", want.out_second, result.out_second);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("calendar_add_seconds_core_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_pct = 0;
    foreach (directed_rows[i]) begin
      drive_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        drive_request(random_request(), 1'b0, '0);
      end
    end
    start <= 1'b0;

    while (pending_times.size() != 0) begin
      @(posedge clk);
    end
    repeat (cas_pkg::STAGES + 4) @(posedge clk);

    if (errors == 0) begin
      $display("calendar_add_seconds_core_tb: clean");
    end else begin
      $display("calendar_add_seconds_core_tb: errors");
    end
    $finish;
  end

endmodule
